// File: rtl/tcw_pkg.sv
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int COPY_N     = CELL_COUNT - COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CNT_W  = $clog2(CELL_COUNT + 1);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);

	// field widths
	localparam int REQ_W    = 3;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int ROW_IN_W = 5;
	localparam int COL_IN_W = 7;
	localparam int CELL_W   = 16;
	localparam int POS_W    = 11;

	localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 8'd31;

	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
	localparam logic [CHAR_W-1:0] RETURN_CHAR  = 8'd13;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUT   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MOVE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

	typedef struct packed {
		logic capture;
		logic exec;
		logic copy;
		logic fill;
		logic cnt_inc;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic op_put;
		logic op_clear;
		logic op_read;
		logic scroll_need;
		logic cnt_copy_end;
		logic cnt_fill_end;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/tcw_ram.sv
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/tcw_ctrl.sv
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tcw_pkg::sts_t sts,
	output tcw_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_RDWAIT = 7'b0001000,
		S_COPY   = 7'b0010000,
		S_FILL   = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.fill    = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_fill_end) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.op_clear) begin
					state_d = S_FILL;
				end else if (sts.op_put && sts.scroll_need) begin
					state_d = S_COPY;
				end else if (sts.op_read) begin
					state_d = S_RDWAIT;
				end else if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RDWAIT, S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (sts.cnt_copy_end) begin
					state_d = S_FILL;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_FILL: begin
				cmd.fill    = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.cnt_fill_end) begin
					if (sts.out_free) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded while output slot busy");

	a_fill_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill && sts.cnt_fill_end) |=> (state_q != S_FILL && state_q != S_INIT))
		else $error("fill sweep ran past the last cell");

	a_copy_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy && sts.cnt_copy_end) |=> state_q == S_FILL)
		else $error("scroll copy did not hand over to bottom row fill");
`endif

endmodule

// File: rtl/tcw_dp.sv
module tcw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcw_pkg::cmd_t                 cmd,
	output tcw_pkg::sts_t                 sts,
	input  logic                          cfg_we,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata,
	input  logic [tcw_pkg::REQ_W-1:0]     req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]   color,
	input  logic [tcw_pkg::ROW_IN_W-1:0]  row,
	input  logic [tcw_pkg::COL_IN_W-1:0]  col,
	input  logic [tcw_pkg::CELL_W-1:0]    cell_value,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [tcw_pkg::CELL_W-1:0]    read_data,
	output logic [tcw_pkg::POS_W-1:0]     cursor_pos,
	output logic                          scrolled
);

	// captured request
	logic [tcw_pkg::REQ_W-1:0]    req_q;
	logic [tcw_pkg::CHAR_W-1:0]   char_q;
	logic [tcw_pkg::COLOR_W-1:0]  color_q;
	logic [tcw_pkg::ROW_IN_W-1:0] row_q;
	logic [tcw_pkg::COL_IN_W-1:0] col_q;
	logic [tcw_pkg::CELL_W-1:0]   cell_q;

	logic [tcw_pkg::COLOR_W-1:0] default_color_q;
	logic [tcw_pkg::ROW_W-1:0]   cur_row_q, cur_row_d;
	logic [tcw_pkg::COL_W-1:0]   cur_col_q, cur_col_d;
	logic [tcw_pkg::CNT_W-1:0]   cnt_q;
	logic [tcw_pkg::CELL_W-1:0]  fill_q;
	logic                        scroll_q, scroll_d;
	logic                        out_valid_q;

	logic op_put, op_clear, op_move, op_write, op_read;
	logic is_nl, is_cr, put_write, col_wrap, advance, last_row, scroll_need;
	logic [tcw_pkg::ROW_W-1:0]  row_c;
	logic [tcw_pkg::COL_W-1:0]  col_c;
	logic [tcw_pkg::ADDR_W-1:0] req_addr, cur_addr;
	logic [tcw_pkg::CNT_W-1:0]  cnt_m1;

	logic                        ram_we, ram_re;
	logic [tcw_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_wdata, ram_rdata;

	assign op_put   = (req_q == tcw_pkg::REQ_PUT);
	assign op_clear = (req_q == tcw_pkg::REQ_CLEAR);
	assign op_move  = (req_q == tcw_pkg::REQ_MOVE);
	assign op_write = (req_q == tcw_pkg::REQ_WRITE);
	assign op_read  = (req_q == tcw_pkg::REQ_READ);

	assign is_nl       = (char_q == tcw_pkg::NEWLINE_CHAR);
	assign is_cr       = (char_q == tcw_pkg::RETURN_CHAR);
	assign put_write   = op_put && !is_nl && !is_cr;
	assign col_wrap    = put_write && (cur_col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
	assign advance     = op_put && (is_nl || col_wrap);
	assign last_row    = (cur_row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
	assign scroll_need = advance && last_row;

	// clamp requested row and column
	assign row_c = (int'(row_q) >= tcw_pkg::ROWS) ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)
		: tcw_pkg::ROW_W'(row_q);
	assign col_c = (int'(col_q) >= tcw_pkg::COLUMNS) ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)
		: tcw_pkg::COL_W'(col_q);

	assign req_addr = tcw_pkg::ADDR_W'(int'(row_c) * tcw_pkg::COLUMNS + int'(col_c));
	assign cur_addr = tcw_pkg::ADDR_W'(int'(cur_row_q) * tcw_pkg::COLUMNS + int'(cur_col_q));
	assign cnt_m1   = cnt_q - tcw_pkg::CNT_W'(1);

	// next cursor
	always_comb begin
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		scroll_d  = scroll_q;
		if (cmd.exec) begin
			scroll_d = scroll_need;
			if (op_put) begin
				if (is_nl || is_cr || col_wrap) begin
					cur_col_d = '0;
				end else begin
					cur_col_d = cur_col_q + tcw_pkg::COL_W'(1);
				end
				if (advance && !last_row) begin
					cur_row_d = cur_row_q + tcw_pkg::ROW_W'(1);
				end
			end else if (op_clear) begin
				cur_row_d = '0;
				cur_col_d = '0;
			end else if (op_move) begin
				cur_row_d = row_c;
				cur_col_d = col_c;
			end
		end
	end

	// store port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = cnt_q[tcw_pkg::ADDR_W-1:0];
		ram_wdata = fill_q;
		ram_raddr = req_addr;
		if (cmd.exec) begin
			ram_we    = put_write || op_write;
			ram_waddr = op_write ? req_addr : cur_addr;
			ram_wdata = op_write ? cell_q : {color_q, char_q};
			ram_re    = op_read;
		end else if (cmd.copy) begin
			// read one row down, write the word read last cycle one cell behind
			ram_we    = (cnt_q != '0);
			ram_waddr = cnt_m1[tcw_pkg::ADDR_W-1:0];
			ram_wdata = ram_rdata;
			ram_re    = !sts.cnt_copy_end;
			ram_raddr = tcw_pkg::ADDR_W'(int'(cnt_q) + tcw_pkg::COLUMNS);
		end else if (cmd.fill) begin
			ram_we = 1'b1;
		end
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			char_q  <= char_code;
			color_q <= color;
			row_q   <= row;
			col_q   <= col;
			cell_q  <= cell_value;
		end
		if (cmd.load_out) begin
			read_data  <= op_read ? ram_rdata : '0;
			cursor_pos <= tcw_pkg::POS_W'(int'(cur_row_d) * tcw_pkg::COLUMNS + int'(cur_col_d));
			scrolled   <= scroll_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q <= tcw_pkg::DEFAULT_COLOR_RST;
			cur_row_q       <= '0;
			cur_col_q       <= '0;
			cnt_q           <= '0;
			fill_q          <= '0;
			scroll_q        <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				default_color_q <= cfg_wdata;
			end
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			scroll_q  <= scroll_d;
			if (cmd.exec) begin
				cnt_q <= '0;
				if (op_clear) begin
					fill_q <= {color_q, tcw_pkg::SPACE_CHAR};
				end else if (scroll_need) begin
					fill_q <= {default_color_q, tcw_pkg::SPACE_CHAR};
				end
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + tcw_pkg::CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	assign sts.op_put       = op_put;
	assign sts.op_clear     = op_clear;
	assign sts.op_read      = op_read;
	assign sts.scroll_need  = scroll_need;
	assign sts.cnt_copy_end = (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::COPY_N));
	assign sts.cnt_fill_end = (cnt_q == tcw_pkg::CNT_W'(tcw_pkg::CELL_COUNT - 1));
	assign sts.out_free     = !out_valid_q || out_ready;

`ifndef NO_ASSERTIONS
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cur_row_q) < tcw_pkg::ROWS)
		else $error("cursor row out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cur_col_q) < tcw_pkg::COLUMNS)
		else $error("cursor column out of range");

	a_copy_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("scroll copy reads and writes the same cell");
`endif

endmodule

// File: rtl/text_console_writer.sv
// sequencing: move, write cell and unused codes finish in the exec step, read cell adds a read wait
// put char finishes in exec too, or adds a row copy plus bottom row fill when it scrolls
// clear screen sweeps every cell, one store write per cycle through the single write port
// a request is accepted only once the one before is done; a result still held
// delays the finish of the next request until out_ready takes it
// reset: async active low; cursor 0,0, default color 31, then a zeroing sweep of every cell
module text_console_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: default color for the row a scroll fills in
	input  logic                          cfg_we,
	input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tcw_pkg::REQ_W-1:0]     req_type,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::COLOR_W-1:0]   color,
	input  logic [tcw_pkg::ROW_IN_W-1:0]  row,
	input  logic [tcw_pkg::COL_IN_W-1:0]  col,
	input  logic [tcw_pkg::CELL_W-1:0]    cell_value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcw_pkg::CELL_W-1:0]    read_data,
	output logic [tcw_pkg::POS_W-1:0]     cursor_pos,
	output logic                          scrolled
);

	// the controller sequences each request through its phases:
	// exec (single cell access and cursor update), optional read wait,
	// scroll copy (one cell per cycle, read one row below, write one behind),
	// and fill sweeps for clear, scroll bottom row and the post-reset zeroing
	tcw_pkg::cmd_t cmd;
	tcw_pkg::sts_t sts;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// the datapath holds the cell store, cursor, sweep counter and the
	// result register; the result register lets the next beat be accepted
	// while a finished result still waits for out_ready
	tcw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req_type),
		.char_code  (char_code),
		.color      (color),
		.row        (row),
		.col        (col),
		.cell_value (cell_value),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.read_data  (read_data),
		.cursor_pos (cursor_pos),
		.scrolled   (scrolled)
	);

endmodule
